>>> hdl/kcl_pkg.sv
`timescale 1ns / 1ps

package kcl_pkg;

  localparam logic [7:0] KEY_NONE  = 8'h00;
  localparam logic [7:0] KEY_HASH  = 8'h23;
  localparam logic [7:0] KEY_STAR  = 8'h2A;
  localparam logic [7:0] DIGIT_ONE = 8'h31;  // reset code counts up from '1'

  typedef struct packed {
    logic [7:0] key_code;
    logic       lock_button;
  } in_item_t;

  typedef struct packed {
    logic       unlocked;
    logic       code_change_active;
    logic [2:0] entry_phase;
  } out_item_t;

  // shared request flags, handed from one sub-machine to the next per tick
  typedef struct packed {
    logic lock_req;
    logic change_req;
  } flags_t;

  typedef enum logic [1:0] {
    BTN_IDLE     = 2'd0,
    BTN_WAIT_REL = 2'd1,
    BTN_WAIT_CHG = 2'd2,
    BTN_CHG_RUN  = 2'd3
  } btn_phase_t;

  typedef enum logic [2:0] {
    ENT_LOCKED    = 3'd0,
    ENT_HASH_REL  = 3'd1,
    ENT_WAIT_KEY  = 3'd2,
    ENT_KEY_REL   = 3'd3,
    ENT_UNLOCKED  = 3'd4
  } entry_phase_t;

  typedef enum logic [2:0] {
    CHG_IDLE       = 3'd0,
    CHG_TAKE_KEY   = 3'd1,
    CHG_TAKE_REL   = 3'd2,
    CHG_VERIFY_KEY = 3'd3,
    CHG_VERIFY_REL = 3'd4,
    CHG_SET        = 3'd5
  } chg_phase_t;

endpackage

>>> hdl/kcl_button.sv
`timescale 1ns / 1ps

module kcl_button (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic [7:0]      key,
  input  logic            btn,
  input  kcl_pkg::flags_t flags_in,
  output kcl_pkg::flags_t flags_out
);
  import kcl_pkg::*;

  btn_phase_t phase_r, phase_nxt;

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      BTN_WAIT_REL: begin
        if (!btn) begin
          phase_nxt = BTN_IDLE;
        end else if (key == KEY_STAR) begin
          phase_nxt = BTN_WAIT_CHG;
        end
      end
      BTN_WAIT_CHG: begin
        if (key == KEY_NONE && !btn) phase_nxt = BTN_CHG_RUN;
      end
      BTN_CHG_RUN: begin
        if (!flags_in.change_req) phase_nxt = BTN_IDLE;
      end
      default: begin
        phase_nxt = btn ? BTN_WAIT_REL : BTN_IDLE;
      end
    endcase
  end

  always_comb begin
    flags_out = flags_in;
    case (phase_r)
      BTN_WAIT_REL: begin
        if (!btn) flags_out.lock_req = 1'b1;
      end
      BTN_WAIT_CHG: begin
        if (key == KEY_NONE && !btn) flags_out.change_req = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= BTN_IDLE;
    end else if (adv) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

>>> hdl/kcl_entry.sv
`timescale 1ns / 1ps

module kcl_entry #(
  parameter int MAX_CODE_LEN = 5,
  parameter int NEW_CODE_LEN = 4,
  localparam int STORE_LEN = (MAX_CODE_LEN > NEW_CODE_LEN) ? MAX_CODE_LEN : NEW_CODE_LEN,
  localparam int LEN_W = $clog2(STORE_LEN + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic [7:0]                    key,
  input  kcl_pkg::flags_t               flags_in,
  input  logic [STORE_LEN-1:0][7:0]     stored_code,
  input  logic [LEN_W-1:0]              code_len,
  output kcl_pkg::flags_t               flags_out,
  output kcl_pkg::entry_phase_t         phase_nxt
);
  import kcl_pkg::*;

  entry_phase_t     phase_r;
  logic [LEN_W-1:0] index_r, index_nxt;
  logic [LEN_W-1:0] index_inc;
  logic             hit;
  logic             lf;

  assign lf        = flags_in.lock_req;
  assign index_inc = index_r + LEN_W'(1);

  // key matches the code digit at the current position, position in range
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < STORE_LEN; k++) begin
      if (index_r == LEN_W'(k) && key == stored_code[k]) hit = 1'b1;
    end
    hit = hit && (index_r < code_len);
  end

  always_comb begin
    phase_nxt = phase_r;
    index_nxt = index_r;
    case (phase_r)
      ENT_HASH_REL: begin
        if (key == KEY_NONE && !lf) begin
          phase_nxt = ENT_WAIT_KEY;
        end else if (lf) begin
          phase_nxt = ENT_LOCKED;
        end
      end
      ENT_WAIT_KEY: begin
        if (hit && !lf) begin
          index_nxt = index_inc;
          phase_nxt = (index_inc >= code_len) ? ENT_UNLOCKED : ENT_KEY_REL;
        end else if (key == KEY_HASH && !lf) begin
          phase_nxt = ENT_HASH_REL;
          index_nxt = '0;
        end else if (key == KEY_NONE && !lf) begin
          phase_nxt = phase_r;
        end else begin
          phase_nxt = ENT_LOCKED;
          index_nxt = '0;
        end
      end
      ENT_KEY_REL: begin
        if (key == KEY_NONE && !lf) begin
          phase_nxt = ENT_WAIT_KEY;
        end else if (lf) begin
          phase_nxt = ENT_LOCKED;
        end
      end
      ENT_UNLOCKED: begin
        if (key == KEY_NONE && lf) phase_nxt = ENT_LOCKED;
      end
      default: begin
        phase_nxt = (key == KEY_HASH && !lf) ? ENT_HASH_REL : ENT_LOCKED;
        index_nxt = '0;
      end
    endcase
  end

  // a pending lock request is consumed once the door is locked
  always_comb begin
    flags_out = flags_in;
    if (phase_nxt == ENT_LOCKED) flags_out.lock_req = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ENT_LOCKED;
      index_r <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      index_r <= index_nxt;
    end
  end

endmodule

>>> hdl/kcl_change.sv
`timescale 1ns / 1ps

module kcl_change #(
  parameter int MAX_CODE_LEN = 5,
  parameter int NEW_CODE_LEN = 4,
  localparam int STORE_LEN = (MAX_CODE_LEN > NEW_CODE_LEN) ? MAX_CODE_LEN : NEW_CODE_LEN,
  localparam int LEN_W = $clog2(STORE_LEN + 1),
  localparam int CIDX_W = $clog2(NEW_CODE_LEN + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic [7:0]                    key,
  input  kcl_pkg::flags_t               flags_in,
  output kcl_pkg::flags_t               flags_out,
  output kcl_pkg::chg_phase_t           phase_nxt,
  output logic [STORE_LEN-1:0][7:0]     stored_code_r,
  output logic [LEN_W-1:0]              code_len_r
);
  import kcl_pkg::*;

  localparam logic [CIDX_W-1:0] NEW_LEN_C = CIDX_W'(NEW_CODE_LEN);

  chg_phase_t                     phase_r;
  logic [CIDX_W-1:0]              index_r, index_nxt;
  logic [CIDX_W-1:0]              index_inc;
  logic [NEW_CODE_LEN-1:0][7:0]   new_code_r, new_code_nxt;
  logic [STORE_LEN-1:0][7:0]      stored_code_nxt;
  logic [LEN_W-1:0]               code_len_nxt;
  logic                           take_key;
  logic                           hit;

  assign index_inc = index_r + CIDX_W'(1);

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < NEW_CODE_LEN; k++) begin
      if (index_r == CIDX_W'(k) && key == new_code_r[k]) hit = 1'b1;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    index_nxt = index_r;
    take_key  = 1'b0;
    case (phase_r)
      CHG_TAKE_KEY: begin
        if (index_r >= NEW_LEN_C) begin
          phase_nxt = CHG_VERIFY_KEY;
          index_nxt = '0;
        end else if (key != KEY_NONE) begin
          phase_nxt = CHG_TAKE_REL;
          take_key  = 1'b1;
        end
      end
      CHG_TAKE_REL: begin
        if (key == KEY_NONE) begin
          index_nxt = index_inc;
          phase_nxt = CHG_TAKE_KEY;
        end
      end
      CHG_VERIFY_KEY: begin
        if (hit) begin
          index_nxt = index_inc;
          phase_nxt = (index_inc >= NEW_LEN_C) ? CHG_SET : CHG_VERIFY_REL;
        end else if (key == KEY_NONE) begin
          phase_nxt = phase_r;
        end else begin
          phase_nxt = CHG_IDLE;
          index_nxt = '0;
        end
      end
      CHG_VERIFY_REL: begin
        if (key == KEY_NONE) phase_nxt = CHG_VERIFY_KEY;
      end
      CHG_SET: begin
        phase_nxt = CHG_IDLE;
      end
      default: begin
        phase_nxt = flags_in.change_req ? CHG_TAKE_KEY : CHG_IDLE;
        index_nxt = '0;
      end
    endcase
  end

  // request is dropped on a failed verify and on leaving the set step
  always_comb begin
    flags_out = flags_in;
    case (phase_r)
      CHG_VERIFY_KEY: begin
        if (!hit && key != KEY_NONE) flags_out.change_req = 1'b0;
      end
      CHG_SET: begin
        flags_out.change_req = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    new_code_nxt    = new_code_r;
    stored_code_nxt = stored_code_r;
    code_len_nxt    = code_len_r;
    for (int k = 0; k < NEW_CODE_LEN; k++) begin
      if (take_key && index_r == CIDX_W'(k)) new_code_nxt[k] = key;
    end
    if (phase_nxt == CHG_SET) begin
      for (int k = 0; k < NEW_CODE_LEN; k++) stored_code_nxt[k] = new_code_nxt[k];
      code_len_nxt = LEN_W'(NEW_CODE_LEN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= CHG_IDLE;
      index_r    <= '0;
      new_code_r <= '0;
      code_len_r <= LEN_W'(MAX_CODE_LEN);
      for (int k = 0; k < STORE_LEN; k++) begin
        stored_code_r[k] <= (k < MAX_CODE_LEN) ? DIGIT_ONE + 8'(k) : KEY_NONE;
      end
    end else if (adv) begin
      phase_r       <= phase_nxt;
      index_r       <= index_nxt;
      new_code_r    <= new_code_nxt;
      stored_code_r <= stored_code_nxt;
      code_len_r    <= code_len_nxt;
    end
  end

endmodule

>>> hdl/keypad_code_lock_core.sv
// An accepted input item goes from the input register, once the result register is free,
//   through one pass of the three sub-machines into the result register.
// Throughput: one item per cycle; stall only when both stages are full and out_stall is set.
// Reset (rst_n low, synchronous): door locked, all sub-machines idle, requests clear,
//   stored code back to the ascending digit code, no items in flight, input stalled.
`timescale 1ns / 1ps

module keypad_code_lock_core #(
  parameter int MAX_CODE_LEN = 5,
  parameter int NEW_CODE_LEN = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kcl_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output kcl_pkg::out_item_t out_item
);
  import kcl_pkg::*;

  localparam int STORE_LEN = (MAX_CODE_LEN > NEW_CODE_LEN) ? MAX_CODE_LEN : NEW_CODE_LEN;
  localparam int LEN_W     = $clog2(STORE_LEN + 1);

  // input register stage
  in_item_t  item_r;
  logic      item_valid_r;
  // result register stage
  out_item_t out_item_r, out_item_nxt;
  logic      out_valid_r;

  logic out_free;  // result register can take a new item this cycle
  logic adv;       // registered item steps the machines and moves to the result stage

  // request flags shared by the sub-machines; chained button -> entry -> change
  flags_t flags_r, flags_btn, flags_ent, flags_chg;

  entry_phase_t              entry_nxt;
  chg_phase_t                chg_nxt;
  logic [STORE_LEN-1:0][7:0] stored_code;
  logic [LEN_W-1:0]          code_len;

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = item_valid_r && out_free;
  // nothing is taken while in reset
  assign in_stall = !rst_n || (item_valid_r && !out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid_r <= 1'b1;
    end else if (adv) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) item_r <= in_item;
  end

  // Button watcher: lock request on release, change request on hold + '*' + release.
  kcl_button u_button (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .key       (item_r.key_code),
    .btn       (item_r.lock_button),
    .flags_in  (flags_r),
    .flags_out (flags_btn)
  );

  // Entry machine sees the lock request raised by the button on the same tick.
  kcl_entry #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NEW_CODE_LEN (NEW_CODE_LEN)
  ) u_entry (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .key         (item_r.key_code),
    .flags_in    (flags_btn),
    .stored_code (stored_code),
    .code_len    (code_len),
    .flags_out   (flags_ent),
    .phase_nxt   (entry_nxt)
  );

  // Change machine runs last; it owns the stored code, which entry reads as of
  // the previous tick.
  kcl_change #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NEW_CODE_LEN (NEW_CODE_LEN)
  ) u_change (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .key           (item_r.key_code),
    .flags_in      (flags_ent),
    .flags_out     (flags_chg),
    .phase_nxt     (chg_nxt),
    .stored_code_r (stored_code),
    .code_len_r    (code_len)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (adv) begin
      flags_r <= flags_chg;
    end
  end

  // result reflects the state after all three machines have stepped
  always_comb begin
    out_item_nxt.unlocked           = (entry_nxt == ENT_UNLOCKED);
    out_item_nxt.code_change_active = chg_nxt inside {CHG_TAKE_KEY, CHG_TAKE_REL,
                                                      CHG_VERIFY_KEY, CHG_VERIFY_REL};
    out_item_nxt.entry_phase        = entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> hdl/kcl_checks.sv
`timescale 1ns / 1ps

module kcl_checks (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input kcl_pkg::out_item_t out_item
);
  import kcl_pkg::*;

  // input side only backs up when a result is waiting and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // every accepted item has a result showing afterwards
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  // unlock drive matches the entry phase reported with it
  a_unlock_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.unlocked == (out_item.entry_phase == 3'(ENT_UNLOCKED))))
    else $error("unlock drive disagrees with entry phase");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind keypad_code_lock_core kcl_checks u_kcl_checks (.*);

>>> bench/keypad_code_lock_core_tb.sv
`timescale 1ns / 1ps

module keypad_code_lock_core_tb;

  import kcl_pkg::*;

  localparam int MAX_CODE_LEN = 5;
  localparam int NEW_CODE_LEN = 4;
  localparam int STORE_LEN    = (MAX_CODE_LEN > NEW_CODE_LEN) ? MAX_CODE_LEN : NEW_CODE_LEN;
  localparam int RANDOM_ITEMS = 1350;
  localparam int LONG_HOLD    = 400;     // receiver hold-off, in cycles
  localparam int HOLD_AFTER   = 300;     // results seen before the hold-off starts
  localparam int TAIL_CYCLES  = 20;
  localparam int LIMIT_CYCLES = 400000;

  // Everything the lock remembers between ticks.
  typedef struct {
    btn_phase_t   btn_ph;
    entry_phase_t ent_ph;
    chg_phase_t   chg_ph;
    logic         lock_req;
    logic         chg_req;
    logic [2:0]   ent_idx;
    logic [2:0]   chg_idx;
    logic [7:0]   code [0:STORE_LEN-1];
    logic [2:0]   code_len;
    logic [7:0]   fresh [0:NEW_CODE_LEN-1];
  } lock_state_t;

  // One queued key event; drain makes the sender wait for every status first.
  typedef struct packed {
    in_item_t ev;
    logic     drain;
  } key_event_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  key_event_t  key_events_q [$];   // stimulus not yet offered
  out_item_t   status_due_q [$];   // predicted status items, oldest first
  lock_state_t gen_st;             // lock state as the stimulus writer sees it
  lock_state_t chk_st;             // lock state stepped on each accepted item
  logic        drain_next = 1'b0;
  int          gen_cnt = 0;

  int   items_in = 0;
  int   results = 0;
  int   errors = 0;
  int   unlocks = 0;
  int   code_updates = 0;
  int   cycles = 0;
  logic in_taken = 1'b0;

  always #4 clk = ~clk;

  keypad_code_lock_core #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .NEW_CODE_LEN(NEW_CODE_LEN)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // ---------------------------------------------------------------------------
  // Lock behavior, one tick per call
  // ---------------------------------------------------------------------------

  function automatic lock_state_t lock_reset();
    lock_state_t s;
    s.btn_ph   = BTN_IDLE;
    s.ent_ph   = ENT_LOCKED;
    s.chg_ph   = CHG_IDLE;
    s.lock_req = 1'b0;
    s.chg_req  = 1'b0;
    s.ent_idx  = '0;
    s.chg_idx  = '0;
    for (int j = 0; j < STORE_LEN; j++) begin
      s.code[j] = (j < MAX_CODE_LEN) ? DIGIT_ONE + 8'(j) : KEY_NONE;
    end
    s.code_len = 3'(MAX_CODE_LEN);
    for (int j = 0; j < NEW_CODE_LEN; j++) begin
      s.fresh[j] = KEY_NONE;
    end
    return s;
  endfunction

  // Button watcher, then entry, then code change; status taken after all three.
  function automatic out_item_t advance_lock(inout lock_state_t s, input in_item_t it);
    logic [7:0] k;
    logic       b;
    logic       lf;
    logic       hit;
    out_item_t  o;
    k = it.key_code;
    b = it.lock_button;

    case (s.btn_ph)
      BTN_WAIT_REL: begin
        if (!b) begin
          s.btn_ph   = BTN_IDLE;
          s.lock_req = 1'b1;
        end else if (k == KEY_STAR) begin
          s.btn_ph = BTN_WAIT_CHG;
        end
      end
      BTN_WAIT_CHG: begin
        if (k == KEY_NONE && !b) begin
          s.btn_ph  = BTN_CHG_RUN;
          s.chg_req = 1'b1;
        end
      end
      BTN_CHG_RUN: begin
        if (!s.chg_req) s.btn_ph = BTN_IDLE;
      end
      default: begin
        if (b) s.btn_ph = BTN_WAIT_REL;
        else s.btn_ph = BTN_IDLE;
      end
    endcase

    lf = s.lock_req;
    case (s.ent_ph)
      ENT_HASH_REL, ENT_KEY_REL: begin
        if (k == KEY_NONE && !lf) s.ent_ph = ENT_WAIT_KEY;
        else if (lf) s.ent_ph = ENT_LOCKED;
      end
      ENT_WAIT_KEY: begin
        // out-of-range position counts as a miss
        hit = 1'b0;
        if (s.ent_idx < s.code_len && s.ent_idx < STORE_LEN) hit = (k == s.code[s.ent_idx]);
        // a matching key wins over '#' restart
        if (hit && !lf) begin
          s.ent_ph  = ENT_KEY_REL;
          s.ent_idx = s.ent_idx + 3'd1;
          if (s.ent_idx >= s.code_len) s.ent_ph = ENT_UNLOCKED;
        end else if (k == KEY_HASH && !lf) begin
          s.ent_ph  = ENT_HASH_REL;
          s.ent_idx = '0;
        end else if (k == KEY_NONE && !lf) begin
          // still waiting
        end else begin
          s.ent_ph  = ENT_LOCKED;
          s.ent_idx = '0;
        end
      end
      ENT_UNLOCKED: begin
        if (k == KEY_NONE && lf) s.ent_ph = ENT_LOCKED;
      end
      default: begin
        // '#' while locked always starts at position 0
        if (k == KEY_HASH && !lf) s.ent_ph = ENT_HASH_REL;
        else s.ent_ph = ENT_LOCKED;
        s.ent_idx = '0;
      end
    endcase
    if (s.ent_ph == ENT_LOCKED) s.lock_req = 1'b0;

    case (s.chg_ph)
      CHG_TAKE_KEY: begin
        if (s.chg_idx >= NEW_CODE_LEN) begin
          s.chg_ph  = CHG_VERIFY_KEY;
          s.chg_idx = '0;
        end else if (k != KEY_NONE) begin
          s.chg_ph             = CHG_TAKE_REL;
          s.fresh[s.chg_idx]   = k;
        end
      end
      CHG_TAKE_REL: begin
        if (k == KEY_NONE) begin
          s.chg_idx = s.chg_idx + 3'd1;
          s.chg_ph  = CHG_TAKE_KEY;
        end
      end
      CHG_VERIFY_KEY: begin
        hit = 1'b0;
        if (s.chg_idx < NEW_CODE_LEN) hit = (k == s.fresh[s.chg_idx]);
        if (hit) begin
          s.chg_ph  = CHG_VERIFY_REL;
          s.chg_idx = s.chg_idx + 3'd1;
          if (s.chg_idx >= NEW_CODE_LEN) s.chg_ph = CHG_SET;
        end else if (k == KEY_NONE) begin
          // still waiting
        end else begin
          s.chg_ph  = CHG_IDLE;
          s.chg_req = 1'b0;
          s.chg_idx = '0;
        end
      end
      CHG_VERIFY_REL: begin
        if (k == KEY_NONE) s.chg_ph = CHG_VERIFY_KEY;
      end
      CHG_SET: begin
        s.chg_req = 1'b0;
        s.chg_ph  = CHG_IDLE;
      end
      default: begin
        if (s.chg_req) s.chg_ph = CHG_TAKE_KEY;
        else s.chg_ph = CHG_IDLE;
        s.chg_idx = '0;
      end
    endcase
    if (s.chg_ph == CHG_SET) begin
      for (int j = 0; j < NEW_CODE_LEN; j++) begin
        s.code[j] = s.fresh[j];
      end
      s.code_len = 3'(NEW_CODE_LEN);
    end

    o.unlocked           = (s.ent_ph == ENT_UNLOCKED);
    o.code_change_active = (s.chg_ph == CHG_TAKE_KEY) || (s.chg_ph == CHG_TAKE_REL) ||
                           (s.chg_ph == CHG_VERIFY_KEY) || (s.chg_ph == CHG_VERIFY_REL);
    o.entry_phase        = s.ent_ph;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus writers; gen_st tracks the lock so sequences can be well formed
  // ---------------------------------------------------------------------------

  task automatic push_key(input logic [7:0] k, input logic b);
    key_event_t e;
    e.ev.key_code    = k;
    e.ev.lock_button = b;
    e.drain          = drain_next;
    drain_next       = 1'b0;
    void'(advance_lock(gen_st, e.ev));
    key_events_q.push_back(e);
    gen_cnt++;
  endtask

  // Flip one bit of a key; never lands on "no key".
  function automatic logic [7:0] wrong_key(input logic [7:0] k);
    logic [7:0] w;
    w = k ^ (8'h01 << $urandom_range(0, 7));
    if (w == KEY_NONE) w = 8'hFF;
    return w;
  endfunction

  // Mostly digits, some '#' and '*', some anything nonzero.
  function automatic logic [7:0] code_key();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 8'h30 + 8'($urandom_range(0, 9));
    if (r < 15) return KEY_HASH;
    if (r < 17) return KEY_STAR;
    return 8'($urandom_range(1, 255));
  endfunction

  // Walk the lock back to locked and idle: finish or abort a code change,
  // release the button, relock with a button press.
  task automatic settle();
    int n;
    n = 0;
    while (!(gen_st.btn_ph == BTN_IDLE && gen_st.ent_ph == ENT_LOCKED &&
             gen_st.chg_ph == CHG_IDLE && !gen_st.chg_req) && n < 30) begin
      if (gen_st.chg_ph == CHG_TAKE_KEY && gen_st.chg_idx < NEW_CODE_LEN)
        push_key(8'h30, 1'b0);
      else if (gen_st.chg_ph == CHG_VERIFY_KEY)
        push_key(wrong_key(gen_st.fresh[gen_st.chg_idx[1:0]]), 1'b0);
      else if (gen_st.ent_ph != ENT_LOCKED && gen_st.btn_ph == BTN_IDLE && !gen_st.chg_req)
        push_key(KEY_NONE, 1'b1);
      else
        push_key(KEY_NONE, 1'b0);
      n++;
    end
  endtask

  // '#', release, then each code key with its release; sometimes one slip.
  task automatic try_unlock();
    int         slip_at;
    logic [7:0] k;
    slip_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, gen_st.code_len - 1) : -1;
    repeat ($urandom_range(1, 2)) push_key(KEY_HASH, 1'b0);
    repeat ($urandom_range(1, 2)) push_key(KEY_NONE, 1'b0);
    for (int j = 0; j < gen_st.code_len; j++) begin
      k = gen_st.code[j];
      if (j == slip_at) begin
        if ($urandom_range(0, 1) == 0 && k != KEY_HASH) k = KEY_HASH;
        else k = wrong_key(k);
      end
      repeat ($urandom_range(1, 2)) push_key(k, 1'b0);
      repeat ($urandom_range(1, 2)) push_key(KEY_NONE, 1'b0);
      if (j == slip_at) break;
    end
  endtask

  // Button + '*' request, four new keys, then the check pass; sometimes botched.
  task automatic change_code();
    int         slip_at;
    logic [7:0] k;
    repeat ($urandom_range(1, 2)) push_key(KEY_NONE, 1'b1);
    repeat ($urandom_range(1, 2)) push_key(KEY_STAR, 1'b1);
    if ($urandom_range(0, 1) == 0) push_key(KEY_NONE, 1'b1);   // '*' let go first
    push_key(KEY_NONE, 1'b0);
    for (int j = 0; j < NEW_CODE_LEN; j++) begin
      k = code_key();
      repeat ($urandom_range(1, 2)) push_key(k, 1'b0);
      repeat ($urandom_range(1, 2)) push_key(KEY_NONE, 1'b0);
    end
    push_key(KEY_NONE, 1'b0);
    slip_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NEW_CODE_LEN - 1) : -1;
    for (int j = 0; j < NEW_CODE_LEN; j++) begin
      k = gen_st.fresh[j];
      if (j == slip_at) k = wrong_key(k);
      repeat ($urandom_range(1, 2)) push_key(k, 1'b0);
      repeat ($urandom_range(1, 2)) push_key(KEY_NONE, 1'b0);
      if (j == slip_at) break;
    end
  endtask

  task automatic noise(input int n);
    logic [7:0] k;
    for (int j = 0; j < n; j++) begin
      case ($urandom_range(0, 3))
        0:       k = KEY_NONE;
        1:       k = code_key();
        default: k = 8'($urandom_range(0, 255));
      endcase
      push_key(k, $urandom_range(0, 9) < 3);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of items with random gaps; a drain item waits for all status
  // ---------------------------------------------------------------------------

  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_taken)) begin
      // in reset, or holding an item not yet taken
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (key_events_q.size() == 0 ||
                 (key_events_q[0].drain && status_due_q.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      in_item  <= key_events_q[0].ev;
      in_valid <= 1'b1;
      key_events_q.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Accepted item: step the lock and queue the status it must produce.
  always @(posedge clk) begin : take_item
    out_item_t due;
    in_taken <= rst_n && in_valid && !in_stall;
    if (!rst_n) begin
      chk_st = lock_reset();
    end else if (in_valid && !in_stall) begin
      due = advance_lock(chk_st, in_item);
      status_due_q.push_back(due);
      items_in++;
      if (chk_st.chg_ph == CHG_SET) code_updates++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall mode changes at random; one long hold-off
  // ---------------------------------------------------------------------------

  int   rx_mode = 0;
  int   rx_left = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && results >= HOLD_AFTER) begin
      // block fills up behind this and must stall its input
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_left <= $urandom_range(16, 96);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Status checker: every accepted status against the oldest prediction.
  logic was_unlocked = 1'b0;

  always @(posedge clk) begin : check_status
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results++;
      if (status_due_q.size() == 0) begin
        $display("%0t: status with none pending: unlocked=%0b change=%0b phase=%0d",
                 $time, out_item.unlocked, out_item.code_change_active,
                 out_item.entry_phase);
        errors++;
      end else begin
        want = status_due_q.pop_front();
        if (out_item.unlocked !== want.unlocked ||
            out_item.code_change_active !== want.code_change_active ||
            out_item.entry_phase !== want.entry_phase) begin
          $display("%0t: status %0d mismatch: expected unlocked=%0b change=%0b phase=%0d,",
                   $time, results, want.unlocked, want.code_change_active, want.entry_phase);
          $display("    got unlocked=%0b change=%0b phase=%0d",
                   out_item.unlocked, out_item.code_change_active, out_item.entry_phase);
          errors++;
        end
        if (want.unlocked && !was_unlocked) unlocks++;
        was_unlocked = want.unlocked;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d status items still due", cycles,
               status_due_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic mid_drain;
    mid_drain = 1'b0;
    gen_st    = lock_reset();

    // Directed: key extremes with the button, lock request while locked,
    // a clean unlock with the reset code, relock, and a wrong key.
    push_key(8'hFF, 1'b1);
    push_key(8'h80, 1'b1);
    push_key(8'h01, 1'b0);
    push_key(KEY_HASH, 1'b0);
    push_key(KEY_NONE, 1'b0);
    for (int j = 0; j < MAX_CODE_LEN; j++) begin
      push_key(DIGIT_ONE + 8'(j), 1'b0);
      push_key(KEY_NONE, 1'b0);
    end
    push_key(KEY_NONE, 1'b1);
    push_key(KEY_NONE, 1'b0);
    push_key(KEY_HASH, 1'b0);
    push_key(KEY_NONE, 1'b0);
    push_key(8'h39, 1'b0);
    push_key(KEY_NONE, 1'b0);

    // Random: mostly well-formed unlocks and code changes, some noise.
    drain_next = 1'b1;
    while (gen_cnt < RANDOM_ITEMS + 20) begin
      if (!mid_drain && gen_cnt >= RANDOM_ITEMS / 2) begin
        mid_drain  = 1'b1;
        drain_next = 1'b1;
      end
      if ($urandom_range(0, 6) != 0) settle();
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: try_unlock();
        9, 10, 11, 12, 13, 14:     change_code();
        default:                   noise($urandom_range(1, 8));
      endcase
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (key_events_q.size() != 0 || in_valid) @(posedge clk);
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d key items and %0d status items in %0d cycles",
             items_in, results, cycles);
    $display("Door unlocked %0d times, code replaced %0d times, %0d mismatches",
             unlocks, code_updates, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
